/* hdl/adl_pkg.sv */
// ----------------------------------------------------------------------------
// adl_pkg: archive directory lookup shared definitions
// Widths, field positions, codes and the types passed along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package adl_pkg;

   localparam int MAX_ENTRIES = 256;

   localparam int WORD_W      = 32;
   localparam int SLOT_W      = 8;
   localparam int BLOCK_W     = 17;
   localparam int COUNT_W     = 9;
   localparam int ADDR_W      = 49;
   localparam int STATUS_W    = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = BLOCK_W;

   // request tdata layout, lowest bit first
   localparam int SLOT_LO     = 0;
   localparam int HASH_LO     = SLOT_LO + SLOT_W;
   localparam int OFFS_LO     = HASH_LO + WORD_W;
   localparam int SIZE_LO     = OFFS_LO + WORD_W;
   localparam int START_LO    = SIZE_LO + WORD_W;
   localparam int END_LO      = START_LO + WORD_W;
   localparam int CAP_LO      = END_LO + WORD_W;
   localparam int REQ_BITS    = CAP_LO + WORD_W;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout, lowest bit first
   localparam int ADDR_LO     = 0;
   localparam int LEN_LO      = ADDR_LO + ADDR_W;
   localparam int FSIZE_LO    = LEN_LO + WORD_W;
   localparam int RSP_BITS    = FSIZE_LO + WORD_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_BITS;

   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK             = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_SMALL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_START_PAST_END = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT = 1'b1;

   typedef struct packed {
      logic [WORD_W-1:0] hash;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] hash;
      logic              found;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] size;
   } tok_type;

endpackage

`default_nettype wire

/* hdl/adl_cell.sv */
// ----------------------------------------------------------------------------
// adl_cell: one directory slot of the lookup chain
// Holds one entry and passes the lookup token to the next cell each cycle,
// marking the first matching entry on the way.
// ----------------------------------------------------------------------------
`default_nettype none

module adl_cell
   import adl_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  wire entry_type wr_entry,
   input  wire logic      active,
   input  wire tok_type   up_tok,
   output tok_type        down_tok
);

   entry_type entry_ff;
   tok_type   tok_ff;
   tok_type   tok_in;

   always_comb begin
      tok_in = up_tok;
      if (up_tok.valid && !up_tok.found && active && (entry_ff.hash == up_tok.hash)) begin
         tok_in.found  = 1'b1;
         tok_in.offset = entry_ff.offset;
         tok_in.size   = entry_ff.size;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign down_tok = tok_ff;

endmodule

`default_nettype wire

/* hdl/archive_directory_lookup_core.sv */
// Load request: the entry is written on acceptance; the OK result is sent from S_EMIT.
// Lookup request: the token walks all MAX_ENTRIES cells, one per cycle; the hit
// is taken in S_SCAN, checked in S_MULT and the result is sent from S_EMIT.
// One request is in work at a time; a held result does not block acceptance.
// Reset: block bytes 2048, entry_count 0, no result pending; entries stay
// undefined until loaded, no clearing pass.
// ----------------------------------------------------------------------------
// archive_directory_lookup_core: archive directory with name hash lookup
// Loads entries into a row of cells and answers lookups with byte address,
// read length and file size.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_directory_lookup_core
   import adl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [7:0] entry_slot, [39:8] file_hash, [71:40] entry_block_offset,
   // [103:72] entry_size, [135:104] part_start, [167:136] part_end,
   // [199:168] buffer_capacity
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // [0] req_type
   input  wire logic                   req_tuser,

   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [48:0] byte_address, [80:49] read_length, [112:81] file_size, rest zero
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // [1:0] status
   output logic [STATUS_W-1:0]         rsp_tuser,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MULT, S_EMIT} state_type;

   state_type               state_ff, state_in;
   logic [BLOCK_W-1:0]      blk_size_ff, blk_size_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [WORD_W-1:0]       start_ff, start_in;
   logic [WORD_W-1:0]       end_ff, end_in;
   logic [WORD_W-1:0]       cap_ff, cap_in;
   tok_type                 hit_ff, hit_in;
   logic [ADDR_W-1:0]       product_ff, product_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [WORD_W-1:0]       len_ff, len_in;
   logic [WORD_W-1:0]       fsize_ff, fsize_in;
   logic                    addr_en_ff, addr_en_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]     rsp_user_ff, rsp_user_in;

   logic                    req_accept;
   logic                    csr_accept;
   logic                    load_accept;
   entry_type               wr_entry;
   tok_type                 tok_chain [MAX_ENTRIES+1];
   logic [WORD_W-1:0]       end_sel;
   logic [WORD_W-1:0]       span;
   logic [ADDR_W-1:0]       addr_sum;

   assign req_tready  = (state_ff == S_IDLE) && !reset;
   assign csr_ready   = !reset;
   assign req_accept  = req_tvalid && req_tready;
   assign csr_accept  = csr_valid && csr_ready;
   assign load_accept = req_accept && (req_tuser == REQ_LOAD);

   assign wr_entry.hash   = req_tdata[HASH_LO +: WORD_W];
   assign wr_entry.offset = req_tdata[OFFS_LO +: WORD_W];
   assign wr_entry.size   = req_tdata[SIZE_LO +: WORD_W];

   assign tok_chain[0].valid  = req_accept && (req_tuser == REQ_LOOKUP);
   assign tok_chain[0].hash   = req_tdata[HASH_LO +: WORD_W];
   assign tok_chain[0].found  = 1'b0;
   assign tok_chain[0].offset = '0;
   assign tok_chain[0].size   = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic cell_wr;
      logic cell_active;

      assign cell_wr     = load_accept &&
                           (32'(req_tdata[SLOT_LO +: SLOT_W]) == 32'(i));
      assign cell_active = (32'(count_ff) > 32'(i));

      adl_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (cell_wr),
         .wr_entry (wr_entry),
         .active   (cell_active),
         .up_tok   (tok_chain[i]),
         .down_tok (tok_chain[i+1])
      );
   end

   assign end_sel  = (end_ff == '0) ? hit_ff.size : end_ff;
   assign span     = end_sel - start_ff;
   assign addr_sum = product_ff + ADDR_W'(start_ff);

   always_comb begin
      blk_size_in = blk_size_ff;
      count_in    = count_ff;
      if (csr_accept) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE:  blk_size_in = csr_data[BLOCK_W-1:0];
            CSR_ENTRY_COUNT: count_in    = csr_data[COUNT_W-1:0];
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      cap_in       = cap_ff;
      hit_in       = hit_ff;
      product_in   = product_ff;
      status_in    = status_ff;
      len_in       = len_ff;
      fsize_in     = fsize_ff;
      addr_en_in   = addr_en_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               start_in = req_tdata[START_LO +: WORD_W];
               end_in   = req_tdata[END_LO +: WORD_W];
               cap_in   = req_tdata[CAP_LO +: WORD_W];
               if (req_tuser == REQ_LOAD) begin
                  status_in  = ST_OK;
                  len_in     = '0;
                  fsize_in   = '0;
                  addr_en_in = 1'b0;
                  state_in   = S_EMIT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (tok_chain[MAX_ENTRIES].valid) begin
               hit_in   = tok_chain[MAX_ENTRIES];
               state_in = S_MULT;
            end
         end
         S_MULT: begin
            product_in = ADDR_W'(hit_ff.offset) * ADDR_W'(blk_size_ff);
            len_in     = '0;
            addr_en_in = 1'b0;
            if (!hit_ff.found) begin
               status_in = ST_NOT_FOUND;
               fsize_in  = '0;
            end else if (start_ff > end_sel) begin
               status_in = ST_START_PAST_END;
               fsize_in  = hit_ff.size;
            end else if (span > cap_ff) begin
               status_in = ST_TOO_SMALL;
               fsize_in  = hit_ff.size;
            end else begin
               status_in  = ST_OK;
               fsize_in   = hit_ff.size;
               len_in     = span;
               addr_en_in = 1'b1;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, fsize_ff, len_ff,
                               (addr_en_ff ? addr_sum : {ADDR_W{1'b0}})};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         blk_size_ff  <= BLOCK_W'(2048);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         blk_size_ff  <= blk_size_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         cap_ff       <= cap_in;
         hit_ff       <= hit_in;
         product_ff   <= product_in;
         status_ff    <= status_in;
         len_ff       <= len_in;
         fsize_ff     <= fsize_in;
         addr_en_ff   <= addr_en_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_user_ff  <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

/* hdl/adl_checker.sv */
// ----------------------------------------------------------------------------
// adl_checker: port level checks for the archive directory lookup core
// Watches request acceptance and result contents over time.
// ----------------------------------------------------------------------------
`default_nettype none

module adl_checker
   import adl_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [REQ_DATA_W-1:0]  req_tdata,
   input wire logic                   req_tuser,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [STATUS_W-1:0]    rsp_tuser,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready,
   input wire logic [CSR_INDEX_W-1:0] csr_index,
   input wire logic [CSR_DATA_W-1:0]  csr_data
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one in work");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a request in work");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata[FSIZE_LO-1:0] == '0))
      else $error("error result carries address or length");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind archive_directory_lookup_core adl_checker u_adl_checker (.*);

`default_nettype wire

/* tb/archive_directory_lookup_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// archive_directory_lookup_core_tb: directory load and lookup check
// Loads directory entries and looks up name hashes under a range of block
// sizes and entry counts. Every request is predicted when it is accepted and
// its answer is compared field by field, with random stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module archive_directory_lookup_core_tb;
   import adl_pkg::*;

   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int RSP_HOLD_CYCLES = 2000;
   localparam int SETTLE_CYCLES   = MAX_ENTRIES + 8;

   typedef struct {
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] hash, offs, size, start, pend, cap;
   } dir_request_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   addr;
      logic [WORD_W-1:0]   len;
      logic [WORD_W-1:0]   fsize;
   } dir_answer_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = REQ_LOAD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_BLOCK_SIZE;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // predicted directory and registers
   logic [WORD_W-1:0]  dir_hash [MAX_ENTRIES];
   logic [WORD_W-1:0]  dir_offs [MAX_ENTRIES];
   logic [WORD_W-1:0]  dir_size [MAX_ENTRIES];
   logic [BLOCK_W-1:0] block_bytes  = 17'd2048;
   logic [COUNT_W-1:0] search_count = '0;

   // directory as planned by the request generator
   logic [WORD_W-1:0] plan_hash [MAX_ENTRIES];
   logic [WORD_W-1:0] plan_size [MAX_ENTRIES];

   dir_request_type       requests_waiting[$];
   dir_answer_type        answers_due[$];
   dir_request_type       req_cur;
   dir_answer_type        answer_want;
   logic                  req_busy = 1'b0;
   logic [REQ_DATA_W-1:0] req_word;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int rsp_hold_left  = 0;
   int rsp_hold_armed = 0;
   int rsp_hold_taken = 0;
   int cycle_count    = 0;
   int mismatch_count = 0;

   archive_directory_lookup_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic dir_answer_type directory_answer(dir_request_type r);
      dir_answer_type    a;
      int                limit;
      int                hit;
      logic [WORD_W-1:0] last;
      logic [63:0]       addr;
      a.status = ST_OK;
      a.addr   = '0;
      a.len    = '0;
      a.fsize  = '0;
      if (r.kind == REQ_LOAD) begin
         dir_hash[r.slot] = r.hash;
         dir_offs[r.slot] = r.offs;
         dir_size[r.slot] = r.size;
         return a;
      end
      limit = (search_count > MAX_ENTRIES) ? MAX_ENTRIES : int'(search_count);
      hit = -1;
      for (int i = 0; i < limit && hit < 0; i++)
         if (dir_hash[i] == r.hash) hit = i;
      if (hit < 0) begin
         a.status = ST_NOT_FOUND;
         return a;
      end
      a.fsize = dir_size[hit];
      last = (r.pend == '0) ? dir_size[hit] : r.pend;
      if (r.start > last) begin
         a.status = ST_START_PAST_END;
      end else if (last - r.start > r.cap) begin
         a.status = ST_TOO_SMALL;
      end else begin
         addr = 64'(dir_offs[hit]) * 64'(block_bytes) + 64'(r.start);
         a.addr = addr[ADDR_W-1:0];
         a.len  = last - r.start;
      end
      return a;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_BLOCK_SIZE) block_bytes = data;
      else search_count = data[COUNT_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic queue_load(int slot, logic [WORD_W-1:0] hash, offs, size);
      dir_request_type r;
      r.kind  = REQ_LOAD;
      r.slot  = slot[SLOT_W-1:0];
      r.hash  = hash;
      r.offs  = offs;
      r.size  = size;
      r.start = $urandom;
      r.pend  = $urandom;
      r.cap   = $urandom;
      requests_waiting.push_back(r);
      plan_hash[slot] = hash;
      plan_size[slot] = size;
   endtask

   task automatic queue_lookup(logic [WORD_W-1:0] hash, start, pend, cap);
      dir_request_type r;
      r.kind  = REQ_LOOKUP;
      r.slot  = SLOT_W'($urandom);
      r.hash  = hash;
      r.offs  = $urandom;
      r.size  = $urandom;
      r.start = start;
      r.pend  = pend;
      r.cap   = cap;
      requests_waiting.push_back(r);
   endtask

   task automatic queue_random_load(int slot);
      logic [WORD_W-1:0] hash;
      hash = $urandom;
      if ($urandom_range(9) < 3) hash = plan_hash[$urandom_range(MAX_ENTRIES - 1)];
      queue_load(slot, hash,
                 $urandom_range(1) ? $urandom : $urandom_range(1023),
                 $urandom_range(1) ? $urandom : $urandom_range(65535));
   endtask

   task automatic queue_random_lookup(int limit);
      logic [WORD_W-1:0] hash, fsize, pend, last, start, len, cap;
      int                hit;
      hash = $urandom;
      if (limit > 0 && $urandom_range(9) < 7) hash = plan_hash[$urandom_range(limit - 1)];
      hit = -1;
      for (int i = 0; i < limit && hit < 0; i++)
         if (plan_hash[i] == hash) hit = i;
      fsize = (hit < 0) ? $urandom : plan_size[hit];
      case ($urandom_range(7))
         0, 1: pend = '0;
         2: pend = $urandom;
         default: pend = $urandom_range(fsize);
      endcase
      last = (pend == '0) ? fsize : pend;
      case ($urandom_range(9))
         0: start = last;
         1: start = $urandom;
         default: start = $urandom_range(last);
      endcase
      len = last - start;
      case ($urandom_range(4))
         0: cap = len;
         1: cap = len - 1;
         2: cap = $urandom;
         default: cap = (len > 32'hFFFF_FF00) ? '1 : len + $urandom_range(255);
      endcase
      queue_lookup(hash, start, pend, cap);
   endtask

   task automatic queue_mixed(int n, int limit);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(3) == 0) queue_random_load($urandom_range(MAX_ENTRIES - 1));
         else queue_random_lookup(limit);
      end
   endtask

   task automatic await_drain();
      while (requests_waiting.size() != 0 || req_busy || answers_due.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            answers_due.push_back(directory_answer(req_cur));
            req_busy = 1'b0;
         end
         if (!req_busy) begin
            if (requests_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_cur  = requests_waiting.pop_front();
               req_busy = 1'b1;
               req_word = '0;
               req_word[SLOT_LO +: SLOT_W]  = req_cur.slot;
               req_word[HASH_LO +: WORD_W]  = req_cur.hash;
               req_word[OFFS_LO +: WORD_W]  = req_cur.offs;
               req_word[SIZE_LO +: WORD_W]  = req_cur.size;
               req_word[START_LO +: WORD_W] = req_cur.start;
               req_word[END_LO +: WORD_W]   = req_cur.pend;
               req_word[CAP_LO +: WORD_W]   = req_cur.cap;
               req_tvalid <= 1'b1;
               req_tuser  <= req_cur.kind;
               req_tdata  <= req_word;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // answer monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("unexpected answer, status", 64'(rsp_tuser), '0);
            end else begin
               answer_want = answers_due.pop_front();
               if (rsp_tuser !== answer_want.status)
                  report_mismatch("status", 64'(rsp_tuser), 64'(answer_want.status));
               if (rsp_tdata[ADDR_LO +: ADDR_W] !== answer_want.addr)
                  report_mismatch("byte_address", 64'(rsp_tdata[ADDR_LO +: ADDR_W]),
                                  64'(answer_want.addr));
               if (rsp_tdata[LEN_LO +: WORD_W] !== answer_want.len)
                  report_mismatch("read_length", 64'(rsp_tdata[LEN_LO +: WORD_W]),
                                  64'(answer_want.len));
               if (rsp_tdata[FSIZE_LO +: WORD_W] !== answer_want.fsize)
                  report_mismatch("file_size", 64'(rsp_tdata[FSIZE_LO +: WORD_W]),
                                  64'(answer_want.fsize));
               if (rsp_tdata[RSP_DATA_W-1:RSP_BITS] !== '0)
                  report_mismatch("pad bits", 64'(rsp_tdata[RSP_DATA_W-1:RSP_BITS]), '0);
            end
         end
         rsp_tready <= (rsp_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_hold_armed != rsp_hold_taken) begin
         rsp_hold_left  <= RSP_HOLD_CYCLES;
         rsp_hold_taken <= rsp_hold_armed;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int count;
      // start the plan from an empty directory
      for (int s = 0; s < MAX_ENTRIES; s++) begin
         plan_hash[s] = '0;
         plan_size[s] = '0;
      end
      send_idle_pct = 21;
      recv_idle_pct = 65;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_BLOCK_SIZE, 17'd2048);
      write_csr(CSR_ENTRY_COUNT, '0);
      queue_lookup('0, '0, '0, '1);
      queue_load(0, '0, '1, '1);
      queue_load(1, '1, '0, '0);
      queue_load(2, 32'h1234_5678, 32'd100, 32'd1000);
      queue_load(3, 32'h1234_5678, 32'd200, 32'd50);
      for (int s = 4; s < 8; s++) queue_load(s, $urandom, $urandom, $urandom_range(9999));
      queue_load(MAX_ENTRIES - 1, $urandom, $urandom, $urandom);
      await_drain();

      write_csr(CSR_BLOCK_SIZE, '1);
      write_csr(CSR_ENTRY_COUNT, 17'd8);
      queue_lookup('0, '0, '0, '1);
      queue_lookup('1, '0, '0, '0);
      queue_lookup('1, 32'd1, '0, '1);
      queue_lookup(32'h1234_5678, 32'd10, '0, 32'd990);
      queue_lookup(32'h1234_5678, 32'd10, '0, 32'd989);
      queue_lookup(32'h1234_5678, 32'd1000, '0, '0);
      queue_lookup(32'h1234_5678, 32'd1001, '0, '1);
      queue_lookup(32'h1234_5678, 32'd5, 32'd2000, 32'd1995);
      queue_lookup('0, '1, '1, '0);
      queue_lookup(32'hDEAD_BEEF, '0, '0, '1);
      queue_lookup(plan_hash[7], '0, '0, '1);
      await_drain();

      write_csr(CSR_BLOCK_SIZE, '0);
      write_csr(CSR_ENTRY_COUNT, 17'd1);
      queue_lookup('0, 32'd77, '0, '1);
      queue_lookup('1, '0, '0, '1);
      await_drain();

      // fill the rest of the directory while looking up the first entries
      write_csr(CSR_BLOCK_SIZE, 17'h10000);
      write_csr(CSR_ENTRY_COUNT, 17'd8);
      for (int s = 8; s < MAX_ENTRIES; s++) begin
         queue_random_load(s);
         if ($urandom_range(2) == 0) queue_random_lookup(8);
      end
      await_drain();

      write_csr(CSR_BLOCK_SIZE, 17'd1);
      write_csr(CSR_ENTRY_COUNT, 17'(MAX_ENTRIES));
      queue_mixed(170, MAX_ENTRIES);
      await_drain();

      send_idle_pct = 65;
      recv_idle_pct = 21;
      write_csr(CSR_BLOCK_SIZE, 17'($urandom_range(65536, 1)));
      write_csr(CSR_ENTRY_COUNT, 17'd511);
      queue_mixed(200, MAX_ENTRIES);
      await_drain();

      count = $urandom_range(MAX_ENTRIES, 1);
      write_csr(CSR_BLOCK_SIZE, 17'h10000);
      write_csr(CSR_ENTRY_COUNT, 17'(count));
      queue_mixed(200, count);
      await_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(CSR_BLOCK_SIZE, 17'd2048);
      write_csr(CSR_ENTRY_COUNT, 17'h1FE00 | 17'd300);
      queue_mixed(200, MAX_ENTRIES);
      rsp_hold_armed++;
      await_drain();

      count = $urandom_range(MAX_ENTRIES, 1);
      write_csr(CSR_BLOCK_SIZE, 17'($urandom_range(131071)));
      write_csr(CSR_ENTRY_COUNT, 17'(count));
      queue_mixed(200, count);
      await_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
hdl/adl_pkg.sv
hdl/adl_cell.sv
hdl/archive_directory_lookup_core.sv
hdl/adl_checker.sv
tb/archive_directory_lookup_core_tb.sv
